### hdl/iaum_pkg.sv
package iaum_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] OP_ADD = 3'd0;
  localparam logic [KIND_W-1:0] OP_SUB = 3'd1;
  localparam logic [KIND_W-1:0] OP_MUL = 3'd2;
  localparam logic [KIND_W-1:0] OP_DIV = 3'd3;
  localparam logic [KIND_W-1:0] OP_MOD = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic iterative;
  } dp_sts_t;

  // parallel-prefix adder, carry-in folded into bit 0 generate
  function automatic logic [WIDTH-1:0] ks_add(input logic [WIDTH-1:0] a,
                                              input logic [WIDTH-1:0] b,
                                              input logic cin);
    logic [WIDTH-1:0] g;
    logic [WIDTH-1:0] p;
    logic [WIDTH-1:0] gn;
    logic [WIDTH-1:0] pn;
    logic [WIDTH-1:0] hp;
    int s;
    int i;
    hp = a ^ b;
    g = a & b;
    p = hp;
    g[0] = g[0] | (p[0] & cin);
    for (s = 1; s < WIDTH; s = s * 2) begin
      gn = g;
      pn = p;
      for (i = s; i < WIDTH; i++) begin
        gn[i] = g[i] | (p[i] & g[i-s]);
        pn[i] = p[i] & p[i-s];
      end
      g = gn;
      p = pn;
    end
    return hp ^ {g[WIDTH-2:0], cin};
  endfunction

endpackage

### hdl/iaum_if.sv
interface iaum_in_if;
  import iaum_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [WIDTH-1:0]   operand_a;
  logic signed [WIDTH-1:0]   operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input kind, input operand_a, input operand_b,
                output ready);
endinterface

interface iaum_out_if;
  import iaum_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WIDTH-1:0]   result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

### hdl/iaum_ctrl.sv
module iaum_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output iaum_pkg::dp_cmd_t cmd,
  input  iaum_pkg::dp_sts_t sts
);
  import iaum_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  assign last = (cnt == CNT_W'(WIDTH - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (sts.iterative) begin
          cmd.step = 1'b1;
          if (last) state_next = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = !out_valid || out_ready;
        if (cmd.finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) cnt <= '0;
      else if (cmd.step) cnt <= cnt + CNT_W'(1);
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### hdl/iaum_dp.sv
module iaum_dp (
  input  logic                           clk,
  input  iaum_pkg::dp_cmd_t              cmd,
  output iaum_pkg::dp_sts_t              sts,
  input  logic [iaum_pkg::KIND_W-1:0]    kind,
  input  logic [iaum_pkg::WIDTH-1:0]     operand_a,
  input  logic [iaum_pkg::WIDTH-1:0]     operand_b,
  output logic [iaum_pkg::WIDTH-1:0]     result
);
  import iaum_pkg::*;

  logic [KIND_W-1:0] kind_r;
  logic [WIDTH-1:0]  x;
  logic [WIDTH-1:0]  y;
  logic [WIDTH-1:0]  z;
  logic              neg_q;
  logic              neg_r;
  logic              div_zero;
  logic              is_div;
  logic [WIDTH-1:0]  mag_a;
  logic [WIDTH-1:0]  mag_b;
  logic [WIDTH:0]    shifted;
  logic [WIDTH:0]    diff;
  logic              ge;
  logic [WIDTH-1:0]  opa;
  logic [WIDTH-1:0]  opb;
  logic              cin;
  logic [WIDTH-1:0]  sum;
  logic [WIDTH-1:0]  res_comb;

  assign is_div = (kind == OP_DIV) || (kind == OP_MOD);
  assign mag_a = operand_a[WIDTH-1] ? ks_add(~operand_a, '0, 1'b1) : operand_a;
  assign mag_b = operand_b[WIDTH-1] ? ks_add(~operand_b, '0, 1'b1) : operand_b;

  assign sts.iterative = (kind_r == OP_MUL) || (kind_r == OP_DIV) || (kind_r == OP_MOD);

  assign shifted = {z, x[WIDTH-1]};
  assign diff = shifted - {1'b0, y};
  assign ge = (shifted >= {1'b0, y});

  always_comb begin
    opa = x;
    opb = '0;
    cin = 1'b0;
    res_comb = '0;
    case (kind_r)
      OP_ADD: begin
        opb = y;
        res_comb = sum;
      end
      OP_SUB: begin
        opb = ~y;
        cin = 1'b1;
        res_comb = sum;
      end
      OP_MUL: res_comb = z;
      OP_DIV: begin
        opa = ~x;
        cin = 1'b1;
        if (!div_zero) res_comb = neg_q ? sum : x;
      end
      OP_MOD: begin
        opa = ~z;
        cin = 1'b1;
        if (!div_zero) res_comb = neg_r ? sum : z;
      end
      default: res_comb = '0;
    endcase
  end

  assign sum = ks_add(opa, opb, cin);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      x <= is_div ? mag_a : operand_a;
      y <= is_div ? mag_b : operand_b;
      z <= '0;
      neg_q <= operand_a[WIDTH-1] ^ operand_b[WIDTH-1];
      neg_r <= operand_a[WIDTH-1];
      div_zero <= (operand_b == '0);
    end else if (cmd.step) begin
      if (kind_r == OP_MUL) begin
        if (y[0]) z <= ks_add(z, x, 1'b0);
        x <= {x[WIDTH-2:0], 1'b0};
        y <= {1'b0, y[WIDTH-1:1]};
      end else begin
        z <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        x <= {x[WIDTH-2:0], ge};
      end
    end
    if (cmd.finish) result <= res_comb;
  end

endmodule

### hdl/integer_add_sub_mul_div_mod_unit.sv
// Signed 32-bit integer unit for add, subtract, multiply, divide and modulo.
// Add and subtract go from the load through the run state to the done state;
// multiply, divide and modulo first take the 32 one-bit steps of the
// shift-and-add multiplier and the restoring divider that share one set of
// work registers. In the done state the result is registered once the output
// register is free, and the input becomes ready again as it is registered, so
// a new transaction is not taken before the last one has finished.
// One transaction is in work at a time; the result sits in an output register,
// so the next transaction is taken while a finished result waits downstream.
// Multiply returns the low 32 bits; divide truncates toward zero; modulo takes
// the sign of the dividend; division or modulo by zero and unused codes give 0.
module integer_add_sub_mul_div_mod_unit (
  input  logic        clk,
  input  logic        rst,
  iaum_in_if.sink     in_ch,
  iaum_out_if.source  out_ch
);
  import iaum_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iaum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  iaum_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (in_ch.kind),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .result    (out_ch.result)
  );

endmodule
